// ----- hdl/spau_pkg.sv -----
// shared types, codes and helpers for the sparse polynomial add and multiply unit
`timescale 1ns / 1ps

package spau_pkg;

	localparam int COEF_W    = 32;
	localparam int EXP_W     = 8;
	localparam int OUT_EXP_W = 5;

	localparam logic KIND_SUM  = 1'b0;
	localparam logic KIND_PROD = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_PROD,
		ST_DRAIN,
		ST_EMIT,
		ST_CLEAR
	} state_t;

	typedef enum logic {
		MAC_ADD,
		MAC_MUL
	} mac_op_t;

	typedef struct packed {
		logic    clr;
		logic    op_v;
		mac_op_t op;
	} mac_ctrl_t;

	typedef struct packed {
		logic                 valid;
		logic                 kind;
		logic [OUT_EXP_W-1:0] exp;
		logic                 last;
	} emit_t;

	// index of the lowest set bit, zero for an empty vector
	function automatic logic [4:0] lowest_set(input logic [31:0] v);
		logic [4:0] r;
		r = '0;
		for (int n = 31; n >= 0; n--) begin
			if (v[n]) begin
				r = 5'(n);
			end
		end
		return r;
	endfunction

endpackage

// ----- hdl/spau_store.sv -----
// dense coefficient stores with present bits for both polynomials
`timescale 1ns / 1ps

module spau_store
	import spau_pkg::*;
#(
	parameter int MAX_EXP = 15,
	localparam int NEXP = MAX_EXP + 1,
	localparam int IW = $clog2(NEXP)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_en,
	input  logic              load_sel,
	input  logic [IW-1:0]     load_idx,
	input  logic [COEF_W-1:0] load_coef,
	input  logic              clear,
	input  logic [IW-1:0]     rd_idx_a,
	input  logic [IW-1:0]     rd_idx_b,
	output logic [COEF_W-1:0] rd_a,
	output logic [COEF_W-1:0] rd_b,
	output logic [NEXP-1:0]   pres_a,
	output logic [NEXP-1:0]   pres_b
);

	logic [COEF_W-1:0] coef_a_q [NEXP];
	logic [COEF_W-1:0] coef_b_q [NEXP];
	logic [NEXP-1:0]   pres_a_q;
	logic [NEXP-1:0]   pres_b_q;
	logic [IW-1:0]     idx_a;
	logic [IW-1:0]     idx_b;
	logic [COEF_W-1:0] sum_new;

	assign idx_a = load_en ? load_idx : rd_idx_a;
	assign idx_b = load_en ? load_idx : rd_idx_b;

	// an absent entry reads as zero
	assign rd_a = pres_a_q[idx_a] ? coef_a_q[idx_a] : '0;
	assign rd_b = pres_b_q[idx_b] ? coef_b_q[idx_b] : '0;

	assign sum_new = (load_sel ? rd_b : rd_a) + load_coef;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pres_a_q <= '0;
			pres_b_q <= '0;
		end else if (clear) begin
			pres_a_q <= '0;
			pres_b_q <= '0;
		end else if (load_en) begin
			if (load_sel) begin
				pres_b_q[load_idx] <= 1'b1;
			end else begin
				pres_a_q[load_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			if (load_sel) begin
				coef_b_q[load_idx] <= sum_new;
			end else begin
				coef_a_q[load_idx] <= sum_new;
			end
		end
	end

	assign pres_a = pres_a_q;
	assign pres_b = pres_b_q;

endmodule

// ----- hdl/spau_mac.sv -----
// shared multiply or add unit with a registered result and an accumulator
`timescale 1ns / 1ps

module spau_mac
	import spau_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mac_ctrl_t         ctrl,
	input  logic [COEF_W-1:0] x,
	input  logic [COEF_W-1:0] y,
	output logic [COEF_W-1:0] acc,
	output logic              busy
);

	logic [COEF_W-1:0]   full_prod;
	logic [COEF_W-1:0]   res_s1;
	logic                v_s1;
	logic [COEF_W-1:0]   acc_q;

	// only the low word of the product is kept
	assign full_prod = x * y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1  <= ctrl.op_v;
			acc_q <= (ctrl.clr ? '0 : acc_q) + (v_s1 ? res_s1 : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op_v) begin
			res_s1 <= (ctrl.op == MAC_MUL) ? full_prod : x + y;
		end
	end

	assign acc  = acc_q;
	assign busy = v_s1;

endmodule

// ----- hdl/spau_seq.sv -----
// sequencer that walks the sum and product terms over the shared unit
`timescale 1ns / 1ps

module spau_seq
	import spau_pkg::*;
#(
	parameter int MAX_EXP = 15,
	localparam int NEXP = MAX_EXP + 1,
	localparam int IW = $clog2(NEXP),
	localparam int NPROD = 2 * MAX_EXP + 1,
	localparam int KW = $clog2(NPROD)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_accept,
	input  logic            in_end,
	input  logic [NEXP-1:0] pres_a,
	input  logic [NEXP-1:0] pres_b,
	input  logic            out_free,
	output logic            in_ready,
	output logic [IW-1:0]   rd_idx_a,
	output logic [IW-1:0]   rd_idx_b,
	output mac_ctrl_t       mac_ctrl,
	output emit_t           emit,
	output logic            clear
);

	state_t          state_q, state_d;
	logic [IW-1:0]   i_q, i_d;
	logic [KW-1:0]   k_q, k_d;
	logic            phase_q, phase_d;
	logic            hit_q, hit_d;
	logic [NEXP-1:0] uni;
	logic            prod_ne;
	logic [4:0]      lo_u;
	logic [5:0]      lo_ab;
	logic [IW-1:0]   i_lo;
	logic [IW-1:0]   i_hi;
	logic [IW-1:0]   j_idx;
	logic            pair;
	logic [KW-1:0]   k_dec;

	function automatic logic [IW-1:0] lo_of(input logic [KW-1:0] k);
		return (k > KW'(MAX_EXP)) ? IW'(k - KW'(MAX_EXP)) : '0;
	endfunction

	assign uni     = pres_a | pres_b;
	assign prod_ne = (|pres_a) && (|pres_b);
	assign lo_u    = lowest_set(32'(uni));
	assign lo_ab   = {1'b0, lowest_set(32'(pres_a))} + {1'b0, lowest_set(32'(pres_b))};
	assign i_lo    = lo_of(k_q);
	assign i_hi    = (k_q < KW'(MAX_EXP)) ? IW'(k_q) : IW'(MAX_EXP);
	assign j_idx   = IW'(k_q - KW'(i_q));
	assign pair    = pres_a[i_q] && pres_b[j_idx];
	assign k_dec   = k_q - KW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			phase_q <= KIND_SUM;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			k_q     <= k_d;
			phase_q <= phase_d;
			hit_q   <= hit_d;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		k_d     = k_q;
		phase_d = phase_q;
		hit_d   = hit_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && in_end) begin
					i_d     = IW'(MAX_EXP);
					phase_d = KIND_SUM;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (uni[i_q]) begin
					state_d = ST_DRAIN;
				end else if (i_q == '0) begin
					if (prod_ne) begin
						k_d     = KW'(2 * MAX_EXP);
						i_d     = IW'(MAX_EXP);
						phase_d = KIND_PROD;
						state_d = ST_PROD;
					end else begin
						state_d = ST_CLEAR;
					end
				end else begin
					i_d = i_q - IW'(1);
				end
			end
			ST_PROD: begin
				hit_d = ((i_q == i_lo) ? 1'b0 : hit_q) | pair;
				if (i_q == i_hi) begin
					state_d = ST_DRAIN;
				end else begin
					i_d = i_q + IW'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (phase_q == KIND_SUM) begin
					if (out_free) begin
						if (i_q == '0) begin
							if (prod_ne) begin
								k_d     = KW'(2 * MAX_EXP);
								i_d     = IW'(MAX_EXP);
								phase_d = KIND_PROD;
								state_d = ST_PROD;
							end else begin
								state_d = ST_CLEAR;
							end
						end else begin
							i_d     = i_q - IW'(1);
							state_d = ST_SUM;
						end
					end
				end else if (!hit_q || out_free) begin
					if (k_q == '0) begin
						state_d = ST_CLEAR;
					end else begin
						k_d     = k_dec;
						i_d     = lo_of(k_dec);
						hit_d   = 1'b0;
						state_d = ST_PROD;
					end
				end
			end
			ST_CLEAR: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		clear         = 1'b0;
		rd_idx_a      = i_q;
		rd_idx_b      = (phase_q == KIND_PROD) ? j_idx : i_q;
		mac_ctrl.clr  = 1'b0;
		mac_ctrl.op_v = 1'b0;
		mac_ctrl.op   = MAC_ADD;
		emit.valid    = 1'b0;
		emit.kind     = phase_q;
		emit.exp      = (phase_q == KIND_PROD) ? OUT_EXP_W'(k_q) : OUT_EXP_W'(i_q);
		emit.last     = (phase_q == KIND_PROD) ? (6'(k_q) == lo_ab)
			: ((5'(i_q) == lo_u) && !prod_ne);
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SUM: begin
				mac_ctrl.clr  = uni[i_q];
				mac_ctrl.op_v = uni[i_q];
				mac_ctrl.op   = MAC_ADD;
			end
			ST_PROD: begin
				mac_ctrl.clr  = (i_q == i_lo);
				mac_ctrl.op_v = pair;
				mac_ctrl.op   = MAC_MUL;
			end
			ST_EMIT: begin
				emit.valid = out_free && ((phase_q == KIND_SUM) || hit_q);
			end
			ST_CLEAR: begin
				clear = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hdl/sparse_polynomial_add_multiply_unit.sv -----
// top level of the sparse polynomial add and multiply unit
`timescale 1ns / 1ps

// Terms arrive on the s_ stream, one beat per term; s_tuser picks the
// polynomial and s_tlast ends the load. A term with zero coefficient is
// ignored, an exponent outside 0..MAX_EXP is dropped and sets a sticky flag.
// The beat carrying tlast starts the walk: the sum terms, highest exponent
// first, each present exponent taking a sum, drain and emit step and each
// absent one only a sum step, then the product terms, highest exponent
// first, with a multiply-accumulate step for each exponent pair plus a drain
// and emit step per product exponent, all on the one shared multiplier and
// accumulator. A clear step then empties the stores, and s_tready rises
// again. Results leave on the m_ stream through an output register;
// m_tlast marks the last term of the run. While the receiver stalls, the
// walk waits at the next term to be emitted. An empty load emits nothing.
// Reset clears the stores, the drop flag and the output valid bit.
module sparse_polynomial_add_multiply_unit
	import spau_pkg::*;
#(
	parameter int MAX_EXP = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // term_coef, term_exp
	input  logic        s_tuser,  // which_poly
	input  logic        s_tlast,  // end_of_load
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // out_exp, out_coef, terms_dropped
	output logic        m_tuser,  // result_kind
	output logic        m_tlast   // last_result
);

	localparam int NEXP = MAX_EXP + 1;
	localparam int IW = $clog2(NEXP);

	logic                 in_accept;
	logic [COEF_W-1:0]    term_coef;
	logic [EXP_W-1:0]     term_exp;
	logic                 exp_ok;
	logic                 load_en;
	logic [IW-1:0]        rd_idx_a;
	logic [IW-1:0]        rd_idx_b;
	logic [COEF_W-1:0]    rd_a;
	logic [COEF_W-1:0]    rd_b;
	logic [NEXP-1:0]      pres_a;
	logic [NEXP-1:0]      pres_b;
	logic                 clear;
	mac_ctrl_t            mac_ctrl;
	emit_t                emit;
	logic [COEF_W-1:0]    acc;
	logic                 mac_busy;
	logic                 out_free;
	logic                 drop_q;
	logic                 m_valid_q;
	logic                 m_kind_q;
	logic                 m_last_q;
	logic                 m_drop_q;
	logic [OUT_EXP_W-1:0] m_exp_q;
	logic [COEF_W-1:0]    m_coef_q;

	assign term_coef = s_tdata[COEF_W-1:0];
	assign term_exp  = s_tdata[COEF_W+EXP_W-1:COEF_W];
	assign in_accept = s_tvalid && s_tready;
	assign exp_ok    = (term_exp <= EXP_W'(MAX_EXP));
	assign load_en   = in_accept && (term_coef != '0) && exp_ok;
	assign out_free  = !m_valid_q || m_tready;

	spau_store #(
		.MAX_EXP(MAX_EXP)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_en  (load_en),
		.load_sel (s_tuser),
		.load_idx (term_exp[IW-1:0]),
		.load_coef(term_coef),
		.clear    (clear),
		.rd_idx_a (rd_idx_a),
		.rd_idx_b (rd_idx_b),
		.rd_a     (rd_a),
		.rd_b     (rd_b),
		.pres_a   (pres_a),
		.pres_b   (pres_b)
	);

	spau_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mac_ctrl),
		.x     (rd_a),
		.y     (rd_b),
		.acc   (acc),
		.busy  (mac_busy)
	);

	spau_seq #(
		.MAX_EXP(MAX_EXP)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_accept(in_accept),
		.in_end   (s_tlast),
		.pres_a   (pres_a),
		.pres_b   (pres_b),
		.out_free (out_free),
		.in_ready (s_tready),
		.rd_idx_a (rd_idx_a),
		.rd_idx_b (rd_idx_b),
		.mac_ctrl (mac_ctrl),
		.emit     (emit),
		.clear    (clear)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
		end else if (in_accept && (term_coef != '0) && !exp_ok) begin
			drop_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			m_kind_q <= emit.kind;
			m_exp_q  <= emit.exp;
			m_coef_q <= acc;
			m_last_q <= emit.last;
			m_drop_q <= drop_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {2'b00, m_drop_q, m_coef_q, m_exp_q};

	// a result is only loaded when the output register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> (!m_tvalid || m_tready))
		else $error("result loaded over an untaken beat");

	// the accumulator is settled whenever a term is emitted
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> !mac_busy)
		else $error("term emitted before accumulation finished");

	// the end of a run leaves both stores empty
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (pres_a == '0) && (pres_b == '0))
		else $error("stores not empty after clear");

	// nothing is left in the shared unit while loading
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !mac_busy)
		else $error("shared unit busy while accepting terms");

endmodule
